### rtl/cfvc_pkg.sv
package cfvc_pkg;

    localparam int SLOTS_DEF         = 16;
    localparam int VEL_LIMIT_XY_DEF  = 39322;
    localparam int VEL_LIMIT_Z_DEF   = 39322;
    localparam int VEL_LIMIT_YAW_DEF = 65536;

    localparam int MODE_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int POS_W      = 32;
    localparam int ANG_W      = 19;
    localparam int CMD_W      = 19;
    localparam int NCNT_W     = 5;
    localparam int GAIN_W     = 16;
    localparam int INTEG_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ERR_W      = POS_W + 3;
    localparam int MUL_A_W    = ERR_W + 1;
    localparam int YAW_ERR_W  = ANG_W + 1;

    localparam logic [MODE_W-1:0] MODE_NB   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OFS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_SLOT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_XY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_XY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KP_Z     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KD_Z     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KP_YAW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KI_YAW   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KD_YAW   = 3'd7;

    localparam int PI_Q     = 205887;
    localparam int TWO_PI_Q = 411775;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        JOB_NB,
        JOB_OFS,
        JOB_TICK
    } job_kind_t;

    typedef struct packed {
        job_kind_t                kind;
        logic [SLOT_W-1:0]        slot;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [ANG_W-1:0]  heading;
        logic signed [POS_W-1:0]  vel_x;
        logic signed [POS_W-1:0]  vel_y;
        logic signed [POS_W-1:0]  vel_z;
        logic signed [POS_W-1:0]  yaw_rate;
        logic signed [POS_W-1:0]  target_z;
        logic signed [ANG_W-1:0]  target_yaw;
    } job_t;

    typedef struct packed {
        logic empty;
        job_t head;
    } q_stat_t;

    typedef struct packed {
        logic [SLOT_W-1:0] own_slot;
        logic [GAIN_W-1:0] kp_xy;
        logic [GAIN_W-1:0] kd_xy;
        logic [GAIN_W-1:0] kp_z;
        logic [GAIN_W-1:0] kd_z;
        logic [GAIN_W-1:0] kp_yaw;
        logic [GAIN_W-1:0] ki_yaw;
        logic [GAIN_W-1:0] kd_yaw;
    } cfg_t;

    // drop 8 fraction bits (floor) and clamp to +-lim
    function automatic logic [CMD_W-1:0] sat_cmd(input logic signed [63:0] acc,
                                                 input logic signed [63:0] lim);
        logic signed [63:0] r;
        r = acc >>> 8;
        if (r > lim)
            r = lim;
        else if (r < -lim)
            r = -lim;
        return r[CMD_W-1:0];
    endfunction

endpackage

### rtl/cfvc_in_if.sv
interface cfvc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [cfvc_pkg::MODE_W-1:0]            mode;
    logic [cfvc_pkg::SLOT_W-1:0]            slot;
    logic signed [cfvc_pkg::POS_W-1:0]      pos_x;
    logic signed [cfvc_pkg::POS_W-1:0]      pos_y;
    logic signed [cfvc_pkg::POS_W-1:0]      pos_z;
    logic signed [cfvc_pkg::ANG_W-1:0]      heading;
    logic signed [cfvc_pkg::POS_W-1:0]      vel_x;
    logic signed [cfvc_pkg::POS_W-1:0]      vel_y;
    logic signed [cfvc_pkg::POS_W-1:0]      vel_z;
    logic signed [cfvc_pkg::POS_W-1:0]      yaw_rate;
    logic signed [cfvc_pkg::POS_W-1:0]      target_z;
    logic signed [cfvc_pkg::ANG_W-1:0]      target_yaw;

    modport source (output valid, mode, slot, pos_x, pos_y, pos_z, heading, vel_x, vel_y,
                    vel_z, yaw_rate, target_z, target_yaw, input ready);
    modport sink (input valid, mode, slot, pos_x, pos_y, pos_z, heading, vel_x, vel_y,
                  vel_z, yaw_rate, target_z, target_yaw, output ready);
endinterface

### rtl/cfvc_out_if.sv
interface cfvc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cfvc_pkg::CMD_W-1:0]      cmd_vel_x;
    logic signed [cfvc_pkg::CMD_W-1:0]      cmd_vel_y;
    logic signed [cfvc_pkg::CMD_W-1:0]      cmd_vel_z;
    logic signed [cfvc_pkg::CMD_W-1:0]      cmd_yaw_rate;
    logic [cfvc_pkg::NCNT_W-1:0]            neighbor_count;

    modport source (output valid, cmd_vel_x, cmd_vel_y, cmd_vel_z, cmd_yaw_rate,
                    neighbor_count, input ready);
    modport sink (input valid, cmd_vel_x, cmd_vel_y, cmd_vel_z, cmd_yaw_rate,
                  neighbor_count, output ready);
endinterface

### rtl/cfvc_front.sv
module cfvc_front #(
    parameter int SLOTS = cfvc_pkg::SLOTS_DEF
) (
    cfvc_in_if.sink         sample,
    input  logic            q_full,
    output logic            push,
    output cfvc_pkg::job_t  job
);
    import cfvc_pkg::*;

    logic keep;

    // unused mode and out-of-range slot writes are swallowed here
    always_comb
    begin
        keep           = 1'b0;
        job.kind       = JOB_TICK;
        job.slot       = sample.slot;
        job.pos_x      = sample.pos_x;
        job.pos_y      = sample.pos_y;
        job.pos_z      = sample.pos_z;
        job.heading    = sample.heading;
        job.vel_x      = sample.vel_x;
        job.vel_y      = sample.vel_y;
        job.vel_z      = sample.vel_z;
        job.yaw_rate   = sample.yaw_rate;
        job.target_z   = sample.target_z;
        job.target_yaw = sample.target_yaw;
        case (sample.mode)
            MODE_NB:
            begin
                job.kind = JOB_NB;
                keep     = int'(sample.slot) < SLOTS;
            end
            MODE_OFS:
            begin
                job.kind = JOB_OFS;
                keep     = int'(sample.slot) < SLOTS;
            end
            MODE_TICK:
            begin
                job.kind = JOB_TICK;
                keep     = 1'b1;
            end
            default:
            begin
                job.kind = JOB_TICK;
                keep     = 1'b0;
            end
        endcase
    end

    assign sample.ready = !q_full;
    assign push         = sample.valid && !q_full && keep;

endmodule

### rtl/cfvc_queue.sv
module cfvc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cfvc_pkg::job_t      din,
    output logic                full,
    input  logic                pop,
    output cfvc_pkg::q_stat_t   stat
);
    import cfvc_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full       = cnt_reg == (QPTR_W+1)'(QDEPTH);
    assign stat.empty = cnt_reg == '0;
    assign stat.head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### rtl/cfvc_div.sv
module cfvc_div #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);
    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // restoring divide, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, q_reg[NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        diff      = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_next   = {q_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign quo  = q_reg;
    assign done = done_reg;

endmodule

### rtl/cfvc_back.sv
module cfvc_back #(
    parameter int SLOTS         = cfvc_pkg::SLOTS_DEF,
    parameter int VEL_LIMIT_XY  = cfvc_pkg::VEL_LIMIT_XY_DEF,
    parameter int VEL_LIMIT_Z   = cfvc_pkg::VEL_LIMIT_Z_DEF,
    parameter int VEL_LIMIT_YAW = cfvc_pkg::VEL_LIMIT_YAW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cfvc_pkg::cfg_t      cfg,
    input  cfvc_pkg::q_stat_t   q,
    output logic                q_pop,
    cfvc_out_if.source          res
);
    import cfvc_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int SCAN_W = $clog2(SLOTS + 1);
    localparam int SUM_W  = POS_W + 1 + SCAN_W;
    localparam int PROD_W = MUL_A_W + GAIN_W + 1;
    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_KPX  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_KDX  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_KPY  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_KDY  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_KPZ  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_KDZ  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_KPW  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_KDW  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_KILO = 4'd8;
    localparam logic [STEP_W-1:0] STEP_KIHI = 4'd9;
    localparam logic [STEP_W-1:0] STEP_END  = 4'd10;

    localparam logic signed [63:0] KI_CLAMP = 64'sd1 <<< 56;
    localparam logic signed [INTEG_W:0] INTEG_MAX = (INTEG_W+1)'((65'sd1 <<< (INTEG_W-1)) - 1);
    localparam logic signed [INTEG_W:0] INTEG_MIN = -((INTEG_W+1)'(65'sd1 <<< (INTEG_W-1)));

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_OWN  = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_ERR  = 7'b0010000,
        ST_MUL  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t state_reg;

    logic signed [POS_W-1:0] nx_mem [SLOTS];
    logic signed [POS_W-1:0] ny_mem [SLOTS];
    logic signed [POS_W-1:0] ox_mem [SLOTS];
    logic signed [POS_W-1:0] oy_mem [SLOTS];
    logic [SLOTS-1:0]        conn_reg;
    logic [SLOTS-1:0]        ofs_vld_reg;

    logic [IDX_W-1:0]        rd_addr;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [POS_W-1:0] rd_nx_reg, rd_ny_reg, rd_ox_reg, rd_oy_reg;
    logic                    rd_conn_reg, rd_ovld_reg;
    logic                    acc_en_reg;
    logic                    own_ok;

    job_t                    job_reg;
    logic [SCAN_W-1:0]       idx_reg;
    logic [SCAN_W-1:0]       cnt_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg;
    logic signed [POS_W:0]   dx, dy;
    logic signed [POS_W-1:0] ox_reg, oy_reg;

    logic [SUM_W-1:0]        mag_x, mag_y, quo_x, quo_y;
    logic                    div_done_x, div_done_y;
    logic signed [SUM_W+1:0] qx_s, qy_s, ex_full, ey_full;
    logic signed [ERR_W-1:0] ex_reg, ey_reg;
    logic signed [POS_W:0]   ez_reg;
    logic signed [YAW_ERR_W-1:0] ew_raw, ew_next, ew_reg;

    logic [STEP_W-1:0]         step_reg, pstep_reg;
    logic                      pvld_reg;
    logic signed [MUL_A_W-1:0] a_sel;
    logic [GAIN_W-1:0]         g_sel;
    logic signed [PROD_W-1:0]  prod_next, prod_reg;
    logic signed [63:0]        prod_ext;
    logic signed [63:0]        acc_x_reg, acc_y_reg, acc_z_reg, acc_w_reg, ki_acc_reg;
    logic signed [63:0]        ki_c, w_total;

    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_next;

    logic                    fin_go;
    logic                    out_vld_reg;
    logic [CMD_W-1:0]        ox_cmd_reg, oy_cmd_reg, oz_cmd_reg, ow_cmd_reg;
    logic [NCNT_W-1:0]       ncnt_reg;

    assign q_pop   = (state_reg == ST_IDLE) && !q.empty;
    assign wr_addr = IDX_W'(q.head.slot);
    assign own_ok  = int'(cfg.own_slot) < SLOTS;
    assign fin_go  = !out_vld_reg || res.ready;

    always_comb
    begin
        if (state_reg == ST_SCAN && int'(idx_reg) < SLOTS)
            rd_addr = idx_reg[IDX_W-1:0];
        else
            rd_addr = IDX_W'(cfg.own_slot);
    end

    // table writes and registered reads
    always_ff @(posedge clk)
    begin
        if (q_pop && q.head.kind == JOB_NB)
        begin
            nx_mem[wr_addr] <= q.head.pos_x;
            ny_mem[wr_addr] <= q.head.pos_y;
        end
        if (q_pop && q.head.kind == JOB_OFS)
        begin
            ox_mem[wr_addr] <= q.head.pos_x;
            oy_mem[wr_addr] <= q.head.pos_y;
        end
        rd_nx_reg <= nx_mem[rd_addr];
        rd_ny_reg <= ny_mem[rd_addr];
        rd_ox_reg <= ox_mem[rd_addr];
        rd_oy_reg <= oy_mem[rd_addr];
    end

    // unwritten offsets read as zero
    always_comb
    begin
        dx = (POS_W+1)'(rd_nx_reg) - (rd_ovld_reg ? (POS_W+1)'(rd_ox_reg) : '0);
        dy = (POS_W+1)'(rd_ny_reg) - (rd_ovld_reg ? (POS_W+1)'(rd_oy_reg) : '0);
    end

    assign mag_x = sx_reg[SUM_W-1] ? SUM_W'(-sx_reg) : SUM_W'(sx_reg);
    assign mag_y = sy_reg[SUM_W-1] ? SUM_W'(-sy_reg) : SUM_W'(sy_reg);

    cfvc_div #(.NUM_W(SUM_W), .DEN_W(SCAN_W)) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_OWN),
        .num   (mag_x),
        .den   (cnt_reg),
        .quo   (quo_x),
        .done  (div_done_x)
    );

    cfvc_div #(.NUM_W(SUM_W), .DEN_W(SCAN_W)) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_OWN),
        .num   (mag_y),
        .den   (cnt_reg),
        .quo   (quo_y),
        .done  (div_done_y)
    );

    always_comb
    begin
        qx_s    = sx_reg[SUM_W-1] ? -$signed({2'b00, quo_x}) : $signed({2'b00, quo_x});
        qy_s    = sy_reg[SUM_W-1] ? -$signed({2'b00, quo_y}) : $signed({2'b00, quo_y});
        ex_full = qx_s - (SUM_W+2)'(job_reg.pos_x) + (SUM_W+2)'(ox_reg);
        ey_full = qy_s - (SUM_W+2)'(job_reg.pos_y) + (SUM_W+2)'(oy_reg);
        ew_raw  = YAW_ERR_W'(job_reg.target_yaw) - YAW_ERR_W'(job_reg.heading);
        if (ew_raw > YAW_ERR_W'(PI_Q))
            ew_next = ew_raw - YAW_ERR_W'(TWO_PI_Q);
        else if (ew_raw < -YAW_ERR_W'(PI_Q))
            ew_next = ew_raw + YAW_ERR_W'(TWO_PI_Q);
        else
            ew_next = ew_raw;
    end

    always_comb
    begin
        a_sel = '0;
        g_sel = '0;
        case (step_reg)
            STEP_KPX:
            begin
                a_sel = MUL_A_W'(ex_reg);
                g_sel = cfg.kp_xy;
            end
            STEP_KDX:
            begin
                a_sel = MUL_A_W'(job_reg.vel_x);
                g_sel = cfg.kd_xy;
            end
            STEP_KPY:
            begin
                a_sel = MUL_A_W'(ey_reg);
                g_sel = cfg.kp_xy;
            end
            STEP_KDY:
            begin
                a_sel = MUL_A_W'(job_reg.vel_y);
                g_sel = cfg.kd_xy;
            end
            STEP_KPZ:
            begin
                a_sel = MUL_A_W'(ez_reg);
                g_sel = cfg.kp_z;
            end
            STEP_KDZ:
            begin
                a_sel = MUL_A_W'(job_reg.vel_z);
                g_sel = cfg.kd_z;
            end
            STEP_KPW:
            begin
                a_sel = MUL_A_W'(ew_reg);
                g_sel = cfg.kp_yaw;
            end
            STEP_KDW:
            begin
                a_sel = MUL_A_W'(job_reg.yaw_rate);
                g_sel = cfg.kd_yaw;
            end
            STEP_KILO:
            begin
                // integral split in two 24-bit halves
                a_sel = $signed({(MUL_A_W-24)'(0), integ_reg[23:0]});
                g_sel = cfg.ki_yaw;
            end
            STEP_KIHI:
            begin
                a_sel = MUL_A_W'($signed(integ_reg[INTEG_W-1:24]));
                g_sel = cfg.ki_yaw;
            end
            default:
            begin
                a_sel = '0;
                g_sel = '0;
            end
        endcase
        prod_next = a_sel * $signed({1'b0, g_sel});
    end

    assign prod_ext = 64'(prod_reg);

    always_comb
    begin
        if (ki_acc_reg > KI_CLAMP)
            ki_c = KI_CLAMP;
        else if (ki_acc_reg < -KI_CLAMP)
            ki_c = -KI_CLAMP;
        else
            ki_c = ki_acc_reg;
        w_total   = acc_w_reg + ki_c;
        integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(ew_reg);
        if (integ_sum > INTEG_MAX)
            integ_next = INTEG_MAX[INTEG_W-1:0];
        else if (integ_sum < INTEG_MIN)
            integ_next = INTEG_MIN[INTEG_W-1:0];
        else
            integ_next = integ_sum[INTEG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                    job_reg <= q.head;
                sx_reg <= '0;
                sy_reg <= '0;
            end
            ST_SCAN:
            begin
                if (acc_en_reg && rd_conn_reg)
                begin
                    sx_reg <= sx_reg + SUM_W'(dx);
                    sy_reg <= sy_reg + SUM_W'(dy);
                end
            end
            ST_OWN:
            begin
                ox_reg <= (own_ok && rd_ovld_reg) ? rd_ox_reg : '0;
                oy_reg <= (own_ok && rd_ovld_reg) ? rd_oy_reg : '0;
            end
            ST_ERR:
            begin
                ex_reg     <= (cnt_reg == '0) ? '0 : ex_full[ERR_W-1:0];
                ey_reg     <= (cnt_reg == '0) ? '0 : ey_full[ERR_W-1:0];
                ez_reg     <= (POS_W+1)'(job_reg.target_z) - (POS_W+1)'(job_reg.pos_z);
                ew_reg     <= ew_next;
                acc_x_reg  <= '0;
                acc_y_reg  <= '0;
                acc_z_reg  <= '0;
                acc_w_reg  <= '0;
                ki_acc_reg <= '0;
            end
            ST_MUL:
            begin
                if (pvld_reg)
                begin
                    case (pstep_reg)
                        STEP_KPX:  acc_x_reg  <= acc_x_reg + prod_ext;
                        STEP_KDX:  acc_x_reg  <= acc_x_reg - prod_ext;
                        STEP_KPY:  acc_y_reg  <= acc_y_reg + prod_ext;
                        STEP_KDY:  acc_y_reg  <= acc_y_reg - prod_ext;
                        STEP_KPZ:  acc_z_reg  <= acc_z_reg + prod_ext;
                        STEP_KDZ:  acc_z_reg  <= acc_z_reg - prod_ext;
                        STEP_KPW:  acc_w_reg  <= acc_w_reg + prod_ext;
                        STEP_KDW:  acc_w_reg  <= acc_w_reg - prod_ext;
                        STEP_KILO: ki_acc_reg <= ki_acc_reg + prod_ext;
                        STEP_KIHI: ki_acc_reg <= ki_acc_reg + (prod_ext <<< 24);
                        default:   acc_x_reg  <= acc_x_reg;
                    endcase
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    ox_cmd_reg <= sat_cmd(acc_x_reg, 64'(VEL_LIMIT_XY));
                    oy_cmd_reg <= sat_cmd(acc_y_reg, 64'(VEL_LIMIT_XY));
                    oz_cmd_reg <= sat_cmd(acc_z_reg, 64'(VEL_LIMIT_Z));
                    ow_cmd_reg <= sat_cmd(w_total, 64'(VEL_LIMIT_YAW));
                    ncnt_reg   <= (int'(cnt_reg) > 31) ? NCNT_W'(31) : NCNT_W'(cnt_reg);
                end
            end
            default:
            begin
                job_reg <= job_reg;
            end
        endcase
        prod_reg  <= prod_next;
        pstep_reg <= step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            conn_reg    <= '0;
            ofs_vld_reg <= '0;
            rd_conn_reg <= 1'b0;
            rd_ovld_reg <= 1'b0;
            acc_en_reg  <= 1'b0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            step_reg    <= '0;
            pvld_reg    <= 1'b0;
            integ_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            rd_conn_reg <= conn_reg[rd_addr];
            rd_ovld_reg <= ofs_vld_reg[rd_addr];
            acc_en_reg  <= (state_reg == ST_SCAN) && (int'(idx_reg) < SLOTS);
            pvld_reg    <= 1'b0;
            if (res.valid && res.ready)
                out_vld_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        case (q.head.kind)
                            JOB_NB:   conn_reg[wr_addr]    <= 1'b1;
                            JOB_OFS:  ofs_vld_reg[wr_addr] <= 1'b1;
                            JOB_TICK:
                            begin
                                idx_reg   <= '0;
                                cnt_reg   <= '0;
                                state_reg <= ST_SCAN;
                            end
                            default:  state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (acc_en_reg && rd_conn_reg)
                        cnt_reg <= cnt_reg + 1'b1;
                    if (int'(idx_reg) < SLOTS)
                        idx_reg <= idx_reg + 1'b1;
                    else
                        state_reg <= ST_OWN;
                end
                ST_OWN:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done_x && div_done_y)
                        state_reg <= ST_ERR;
                end
                ST_ERR:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (step_reg != STEP_END)
                    begin
                        pvld_reg <= 1'b1;
                        step_reg <= step_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (fin_go)
                    begin
                        integ_reg   <= integ_next;
                        out_vld_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res.valid          = out_vld_reg;
    assign res.cmd_vel_x      = ox_cmd_reg;
    assign res.cmd_vel_y      = oy_cmd_reg;
    assign res.cmd_vel_z      = oz_cmd_reg;
    assign res.cmd_yaw_rate   = ow_cmd_reg;
    assign res.neighbor_count = ncnt_reg;

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && fin_go) |=> out_vld_reg)
        else $error("finished tick did not load a result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (int'(ncnt_reg) <= SLOTS))
        else $error("neighbor count above slot count");

    a_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
        acc_en_reg |-> (state_reg == ST_SCAN))
        else $error("slot accumulate outside the walk");

    a_integ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && fin_go) |=>
        ((integ_reg - $past(integ_reg)) <= 48'sd524288 &&
         (integ_reg - $past(integ_reg)) >= -48'sd524288))
        else $error("heading integral jumped by more than one error");

endmodule

### rtl/consensus_formation_velocity_ctrl.sv
// channel   dir  payload                                           beat when
// sample    in   mode slot pos_x/y/z heading vel_x/y/z yaw_rate     valid && ready
//                target_z target_yaw
// command   out  cmd_vel_x/y/z cmd_yaw_rate neighbor_count          valid && ready
// cfg       in   cfg_we cfg_idx cfg_data                            cfg_we
//
// Position and offset writes are done at the pop itself. A tick pops the job, walks the
// slots (one table read per cycle), reads the own offset, runs the bit-serial average
// divide (SUM_W = 33 + clog2(SLOTS+1)), forms the errors, makes the shared multiplier
// pass and loads the output. Reset clears the connected and offset-written marks;
// no clearing pass. A two-entry queue decouples sample intake from the back end; the
// result register lets the back end finish a tick only once the last beat is taken.
module consensus_formation_velocity_ctrl #(
    parameter int SLOTS         = cfvc_pkg::SLOTS_DEF,
    parameter int VEL_LIMIT_XY  = cfvc_pkg::VEL_LIMIT_XY_DEF,
    parameter int VEL_LIMIT_Z   = cfvc_pkg::VEL_LIMIT_Z_DEF,
    parameter int VEL_LIMIT_YAW = cfvc_pkg::VEL_LIMIT_YAW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cfvc_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [cfvc_pkg::CFG_DATA_W-1:0]   cfg_data,
    cfvc_in_if.sink                           sample,
    cfvc_out_if.source                        command
);
    import cfvc_pkg::*;

    cfg_t    cfg_reg;
    logic    push;
    logic    q_full;
    logic    q_pop;
    job_t    job;
    q_stat_t q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_slot <= '0;
            cfg_reg.kp_xy    <= 16'd256;
            cfg_reg.kd_xy    <= 16'd128;
            cfg_reg.kp_z     <= 16'd256;
            cfg_reg.kd_z     <= 16'd128;
            cfg_reg.kp_yaw   <= 16'd256;
            cfg_reg.ki_yaw   <= 16'd0;
            cfg_reg.kd_yaw   <= 16'd128;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_OWN_SLOT: cfg_reg.own_slot <= cfg_data[SLOT_W-1:0];
                REG_KP_XY:    cfg_reg.kp_xy    <= cfg_data;
                REG_KD_XY:    cfg_reg.kd_xy    <= cfg_data;
                REG_KP_Z:     cfg_reg.kp_z     <= cfg_data;
                REG_KD_Z:     cfg_reg.kd_z     <= cfg_data;
                REG_KP_YAW:   cfg_reg.kp_yaw   <= cfg_data;
                REG_KI_YAW:   cfg_reg.ki_yaw   <= cfg_data;
                REG_KD_YAW:   cfg_reg.kd_yaw   <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    cfvc_front #(.SLOTS(SLOTS)) u_front (
        .sample (sample),
        .q_full (q_full),
        .push   (push),
        .job    (job)
    );

    cfvc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (job),
        .full  (q_full),
        .pop   (q_pop),
        .stat  (q_stat)
    );

    cfvc_back #(
        .SLOTS         (SLOTS),
        .VEL_LIMIT_XY  (VEL_LIMIT_XY),
        .VEL_LIMIT_Z   (VEL_LIMIT_Z),
        .VEL_LIMIT_YAW (VEL_LIMIT_YAW)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .q     (q_stat),
        .q_pop (q_pop),
        .res   (command)
    );

endmodule
